>>> design/csap_pkg.sv
`timescale 1ns / 1ps

package csap_pkg;

  localparam int unsigned TimeoutW = 24;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned SampleW  = 16;

  localparam logic [TimeoutW-1:0] IdleTimeoutRst   = 24'd5000000;
  localparam logic [TimeoutW-1:0] EmptyTimeoutRst  = 24'd3500000;
  localparam logic [PeriodW-1:0]  MeasurePeriodRst = 16'd5000;
  localparam logic [HandleW-1:0]  NoConnHandle     = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_IDLE_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_EMPTY_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_MEASURE_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CONN = 2'd1,
    REQ_POFF = 2'd2,
    REQ_ADC  = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    MODE_NONE  = 5'b00001,
    MODE_CHRG  = 5'b00010,
    MODE_STDBY = 5'b00100,
    MODE_BATT  = 5'b01000,
    MODE_EMPTY = 5'b10000
  } mode_t;

  // charger_state codes
  localparam logic [2:0] STATE_NONE  = 3'd0;
  localparam logic [2:0] STATE_CHRG  = 3'd1;
  localparam logic [2:0] STATE_STDBY = 3'd2;
  localparam logic [2:0] STATE_BATT  = 3'd3;
  localparam logic [2:0] STATE_EMPTY = 3'd4;

  // indication codes
  localparam logic [1:0] IND_NONE  = 2'd0;
  localparam logic [1:0] IND_CHRG  = 2'd1;
  localparam logic [1:0] IND_STDBY = 2'd2;
  localparam logic [1:0] IND_LOW   = 2'd3;

  // notification codes
  localparam logic [1:0] NOTIFY_BATT  = 2'd0;
  localparam logic [1:0] NOTIFY_EMPTY = 2'd1;
  localparam logic [1:0] NOTIFY_STDBY = 2'd2;
  localparam logic [1:0] NOTIFY_CHRG  = 2'd3;

  typedef struct packed {
    logic [TimeoutW-1:0] idle_timeout;
    logic [TimeoutW-1:0] empty_timeout;
    logic [PeriodW-1:0]  measure_period;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic                blocked;
    logic [TimeoutW-1:0] countdown;
    logic                running;
    logic [PeriodW-1:0]  measure_count;
    logic [SampleW-1:0]  last_value;
  } state_t;

  typedef struct packed {
    logic [2:0]         charger_state;
    logic [1:0]         indication;
    logic               notify_valid;
    logic [1:0]         notify_code;
    logic               sample_request;
    logic               battery_event;
    logic [SampleW-1:0] battery_value;
    logic               power_off;
    logic               power_off_allowed;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    c = STATE_NONE;
    unique case (m)
      MODE_NONE:  c = STATE_NONE;
      MODE_CHRG:  c = STATE_CHRG;
      MODE_STDBY: c = STATE_STDBY;
      MODE_BATT:  c = STATE_BATT;
      MODE_EMPTY: c = STATE_EMPTY;
      default:    c = STATE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] mode_ind(mode_t m);
    logic [1:0] c;
    c = IND_NONE;
    unique case (m)
      MODE_CHRG:  c = IND_CHRG;
      MODE_STDBY: c = IND_STDBY;
      MODE_EMPTY: c = IND_LOW;
      default:    c = IND_NONE;
    endcase
    return c;
  endfunction

  function automatic logic charger_active(mode_t m);
    return (m == MODE_CHRG) || (m == MODE_STDBY);
  endfunction

endpackage

>>> design/charger_state_autopoweroff.sv
`timescale 1ns / 1ps
// Each result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle unless out_ready stalls; the single result
// register refills in the same cycle it is drained; in_ready follows the output.
// Reset (rst, synchronous): mode none, countdown stopped, counters and the
// stored sample cleared, timeouts and sample period back to their defaults.

module charger_state_autopoweroff import csap_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [TimeoutW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic                charge_pin_n,
  input  logic                standby_pin_n,
  input  logic [HandleW-1:0]  conn_handle,
  input  logic [SampleW-1:0]  adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          charger_state,
  output logic [1:0]          indication,
  output logic                notify_valid,
  output logic [1:0]          notify_code,
  output logic                sample_request,
  output logic                battery_event,
  output logic [SampleW-1:0]  battery_value,
  output logic                power_off,
  output logic                power_off_allowed
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t result;
  result_t result_next;
  logic    in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  csap_step u_step (
    .cur           (state),
    .cfg           (cfg),
    .req_type      (req_type),
    .charge_pin_n  (charge_pin_n),
    .standby_pin_n (standby_pin_n),
    .conn_handle   (conn_handle),
    .adc_sample    (adc_sample),
    .nxt           (state_next),
    .res           (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout   <= IdleTimeoutRst;
      cfg.empty_timeout  <= EmptyTimeoutRst;
      cfg.measure_period <= MeasurePeriodRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT:   cfg.idle_timeout   <= cfg_data;
        CFG_EMPTY_TIMEOUT:  cfg.empty_timeout  <= cfg_data;
        CFG_MEASURE_PERIOD: cfg.measure_period <= cfg_data[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= MODE_NONE;
      state.blocked       <= 1'b0;
      state.countdown     <= '0;
      state.running       <= 1'b0;
      state.measure_count <= '0;
      state.last_value    <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign charger_state     = result.charger_state;
  assign indication        = result.indication;
  assign notify_valid      = result.notify_valid;
  assign notify_code       = result.notify_code;
  assign sample_request    = result.sample_request;
  assign battery_event     = result.battery_event;
  assign battery_value     = result.battery_value;
  assign power_off         = result.power_off;
  assign power_off_allowed = result.power_off_allowed;

  a_mode_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state.mode))
    else $error("mode register lost its one-hot code");

  a_poff_allowed: assert property (@(posedge clk) disable iff (rst)
    out_valid && power_off |-> power_off_allowed)
    else $error("power-off issued while the charger is active");

  a_conn_stops: assert property (@(posedge clk) disable iff (rst)
    in_fire && (req_type == REQ_CONN) && (conn_handle != NoConnHandle)
    |=> !state.running && state.blocked)
    else $error("live connection did not stop the countdown");

  a_notify_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && notify_valid |->
      (notify_code == NOTIFY_CHRG && charger_state == STATE_CHRG) ||
      (notify_code == NOTIFY_STDBY && charger_state == STATE_STDBY) ||
      (notify_code == NOTIFY_BATT && charger_state == STATE_BATT) ||
      (notify_code == NOTIFY_EMPTY && charger_state == STATE_EMPTY))
    else $error("notification code does not match the new state");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("pending result changed before transfer");

endmodule

>>> design/csap_step.sv
`timescale 1ns / 1ps

module csap_step import csap_pkg::*; (
  input  state_t             cur,
  input  cfg_t               cfg,
  input  logic [1:0]         req_type,
  input  logic               charge_pin_n,
  input  logic               standby_pin_n,
  input  logic [HandleW-1:0] conn_handle,
  input  logic [SampleW-1:0] adc_sample,
  output state_t             nxt,
  output result_t            res
);

  req_t  req;
  logic  expired;
  logic  want_change;
  mode_t target;
  logic  nv;
  logic  [1:0] code;
  logic  sreq;
  logic  bev;
  logic  poff;

  assign req = req_t'(req_type);

  always_comb begin
    nxt         = cur;
    expired     = 1'b0;
    want_change = 1'b0;
    target      = cur.mode;
    nv          = 1'b0;
    code        = NOTIFY_BATT;
    sreq        = 1'b0;
    bev         = 1'b0;
    poff        = 1'b0;

    unique case (req)
      REQ_TICK: begin
        // countdown steps before the pins are looked at
        if (cur.running) begin
          if (cur.countdown <= 24'd1) begin
            expired       = 1'b1;
            nxt.countdown = '0;
            nxt.running   = 1'b0;
          end else begin
            nxt.countdown = cur.countdown - 24'd1;
          end
        end

        if (!charge_pin_n) begin
          target      = MODE_CHRG;
          want_change = 1'b1;
        end else if (!standby_pin_n) begin
          target      = MODE_STDBY;
          want_change = 1'b1;
        end else if (charger_active(cur.mode)) begin
          target      = MODE_BATT;
          want_change = 1'b1;
        end

        if (want_change && (target != cur.mode)) begin
          if ((cur.mode == MODE_BATT) || (cur.mode == MODE_EMPTY)) begin
            nxt.running = 1'b0;
          end
          nv = 1'b1;
          unique case (target)
            MODE_CHRG:  code = NOTIFY_CHRG;
            MODE_STDBY: code = NOTIFY_STDBY;
            MODE_EMPTY: code = NOTIFY_EMPTY;
            MODE_BATT: begin
              code = NOTIFY_BATT;
              if (!cur.blocked) begin
                nxt.countdown = cfg.idle_timeout;
                nxt.running   = 1'b1;
              end
            end
            default: nv = 1'b0;
          endcase
          nxt.mode = target;
        end

        if (cur.measure_count >= cfg.measure_period) begin
          sreq              = 1'b1;
          nxt.measure_count = '0;
        end else begin
          nxt.measure_count = cur.measure_count + 16'd1;
        end

        poff = expired && !cur.blocked && !charger_active(nxt.mode);
      end

      REQ_CONN: begin
        nxt.blocked = (conn_handle != NoConnHandle);
        if (conn_handle != NoConnHandle) begin
          nxt.running = 1'b0;
        end else if (cur.mode == MODE_BATT) begin
          nxt.countdown = cfg.idle_timeout;
          nxt.running   = 1'b1;
        end else if (cur.mode == MODE_EMPTY) begin
          nxt.countdown = cfg.empty_timeout;
          nxt.running   = 1'b1;
        end
      end

      REQ_POFF: poff = !charger_active(cur.mode);

      REQ_ADC: begin
        nxt.last_value = adc_sample;
        bev            = 1'b1;
      end

      default: ;
    endcase

    res.charger_state     = mode_code(nxt.mode);
    res.indication        = mode_ind(nxt.mode);
    res.notify_valid      = nv;
    res.notify_code       = code;
    res.sample_request    = sreq;
    res.battery_event     = bev;
    res.battery_value     = nxt.last_value;
    res.power_off         = poff;
    res.power_off_allowed = !charger_active(nxt.mode);
  end

endmodule
